// ===== sv/q4dd_pkg.sv =====
// Package: widths, command/status structs and helpers for the Q4 dequant dot unit.
`timescale 1ns / 1ps
package q4dd_pkg;

  localparam int ACT_W   = 16;
  localparam int SCALE_W = 16;
  localparam int NIB_W   = 4;
  localparam int PROD_W  = ACT_W + SCALE_W;
  localparam int TERM_W  = PROD_W + NIB_W;
  localparam int SUM_W   = 56;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted input beat
    logic mul_scale;   // activation * scale
    logic mul_weight;  // product * signed nibble
    logic accumulate;  // saturating add into the running sum
    logic sel_second;  // work on the high-nibble element
    logic emit;        // move the running sum to the output register and clear
  } q4dd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic second_valid;
    logic last_item;
    logic out_busy;    // output register holds a beat that is not taken this cycle
  } q4dd_sts_t;

  // Nibble minus 8 is the nibble with its top bit flipped, read as signed.
  function automatic logic signed [NIB_W-1:0] nib_weight(input logic [NIB_W-1:0] nib);
    nib_weight = $signed({~nib[NIB_W-1], nib[NIB_W-2:0]});
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [TERM_W-1:0] term
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(acc) + (SUM_W+1)'(term);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

// ===== sv/q4dd_ctrl.sv =====
// Controller: sequences capture, two multiplies and the add per element, then the emit after a last item.
`timescale 1ns / 1ps
module q4dd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  q4dd_pkg::q4dd_sts_t sts,
  output q4dd_pkg::q4dd_cmd_t cmd
);
  import q4dd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULA  = 3'd1;
  localparam logic [2:0] S_MULW  = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       elem_r, elem_nxt;

  always_comb begin
    state_nxt      = state_r;
    elem_nxt       = elem_r;
    cmd            = '0;
    cmd.sel_second = elem_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          elem_nxt  = 1'b0;
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_scale = 1'b1;
        state_nxt     = S_MULW;
      end
      S_MULW: begin
        cmd.mul_weight = 1'b1;
        state_nxt      = S_ADD;
      end
      S_ADD: begin
        cmd.accumulate = 1'b1;
        if (!elem_r && sts.second_valid) begin
          elem_nxt  = 1'b1;
          state_nxt = S_MULA;
        end else if (sts.last_item) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      elem_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      elem_r  <= elem_nxt;
    end
  end

endmodule

// ===== sv/q4dd_dp.sv =====
// Datapath: input capture, shared multiplier pair, saturating accumulator, output register.
`timescale 1ns / 1ps
module q4dd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [7:0]                        in_weight_byte,
  input  logic signed [q4dd_pkg::ACT_W-1:0]   in_act_first,
  input  logic signed [q4dd_pkg::ACT_W-1:0]   in_act_second,
  input  logic signed [q4dd_pkg::SCALE_W-1:0] in_block_scale,
  input  logic                              in_second_valid,
  input  logic                              in_last_item,
  input  q4dd_pkg::q4dd_cmd_t                 cmd,
  output q4dd_pkg::q4dd_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [q4dd_pkg::SUM_W-1:0]   out_dot_sum
);
  import q4dd_pkg::*;

  logic [2*NIB_W-1:0]         byte_r;
  logic signed [ACT_W-1:0]    act0_r, act1_r;
  logic signed [SCALE_W-1:0]  scale_r;
  logic                       second_r, last_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [TERM_W-1:0]   term_r;
  logic signed [SUM_W-1:0]    acc_r, acc_nxt;
  logic signed [SUM_W-1:0]    out_r;
  logic                       out_valid_r, out_valid_nxt;

  logic signed [ACT_W-1:0]    act_sel;
  logic signed [NIB_W-1:0]    w_sel;

  assign act_sel = cmd.sel_second ? act1_r : act0_r;
  assign w_sel   = cmd.sel_second ? nib_weight(byte_r[2*NIB_W-1:NIB_W])
                                  : nib_weight(byte_r[NIB_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r   <= in_weight_byte;
      act0_r   <= in_act_first;
      act1_r   <= in_act_second;
      scale_r  <= in_block_scale;
      second_r <= in_second_valid;
      last_r   <= in_last_item;
    end
    if (cmd.mul_scale) begin
      prod_r <= PROD_W'(act_sel) * PROD_W'(scale_r);
    end
    if (cmd.mul_weight) begin
      term_r <= TERM_W'(prod_r) * TERM_W'(w_sel);
    end
    if (cmd.emit) begin
      out_r <= acc_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.accumulate) begin
      acc_nxt = sat_add(acc_r, term_r);
    end else if (cmd.emit) begin
      acc_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.second_valid = second_r;
  assign sts.last_item    = last_r;
  assign sts.out_busy     = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_dot_sum = out_r;

endmodule

// ===== sv/q4_block_dequant_dot.sv =====
// Top level: Q4 block dequantize and dot product, controller plus datapath.
//
//  port group  | dir | handshake            | payload
//  in_*        | in  | in_valid / in_ready  | weight_byte, act_first, act_second,
//              |     |                      | block_scale, second_valid, last_item
//  out_*       | out | out_valid / out_ready| dot_sum (56-bit signed, 20 fraction bits)
//
// Each item is captured first; then for each of its one or two elements the unit does
// activation*scale, the nibble multiply and the saturating add, in that order.
// A last item adds an emit step that moves the sum to the output.
// The emit cycle holds while the output register still has an untaken beat.
// Reset clears the accumulator, the controller and the output valid.
`timescale 1ns / 1ps
module q4_block_dequant_dot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_weight_byte,
  input  logic signed [q4dd_pkg::ACT_W-1:0]   in_act_first,
  input  logic signed [q4dd_pkg::ACT_W-1:0]   in_act_second,
  input  logic signed [q4dd_pkg::SCALE_W-1:0] in_block_scale,
  input  logic                                in_second_valid,
  input  logic                                in_last_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [q4dd_pkg::SUM_W-1:0]   out_dot_sum
);
  import q4dd_pkg::*;

  q4dd_cmd_t cmd;
  q4dd_sts_t sts;

  q4dd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  q4dd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_weight_byte  (in_weight_byte),
    .in_act_first    (in_act_first),
    .in_act_second   (in_act_second),
    .in_block_scale  (in_block_scale),
    .in_second_valid (in_second_valid),
    .in_last_item    (in_last_item),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dot_sum     (out_dot_sum)
  );

endmodule

// ===== sv/q4dd_chk.sv =====
// Checker: port-level assertions for the Q4 dequant dot unit, bound to the top level.
`timescale 1ns / 1ps
module q4dd_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last_item,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [q4dd_pkg::SUM_W-1:0] out_dot_sum
);
  import q4dd_pkg::*;

  // a held output beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dot_sum))
    else $error("output beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an item is not done at once: no beat accepted right after another
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in the cycle after a beat");

  // a non-last beat never produces a result right away
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_item && !out_valid |=> !out_valid)
    else $error("result appeared after a non-last beat");

endmodule

bind q4_block_dequant_dot q4dd_chk u_q4dd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_last_item (in_last_item),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_dot_sum  (out_dot_sum)
);
